// ===== rtl/core/piecewise_speed_level_mapper_macros.svh =====
// ----------------------------------------------------------------------------
// Speed level mapper assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_SPEED_LEVEL_MAPPER_MACROS_SVH
`define PIECEWISE_SPEED_LEVEL_MAPPER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PSL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("speed level mapper assertion failed");

// implication after a fixed number of cycles
`define PSL_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error("speed level mapper assertion failed");

`else

`define PSL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PSL_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons)

`endif

`endif

// ===== rtl/core/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// Speed level mapper package
// Shared widths, codes and the record that travels down the divider chain.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int CMD_W         = 21;  // Q16.4 signed command
  localparam int LEVEL_W       = 17;  // rounded magnitude, 0..65536
  localparam int BP_W          = 16;
  localparam int NUM_BP        = 9;
  localparam int NUM_SEG       = NUM_BP - 1;
  localparam int SEG_W         = $clog2(NUM_SEG);
  localparam int BP_IDX_W      = $clog2(NUM_BP);
  localparam int NUM_DIV_CELLS = 4;   // quotient 0..8
  localparam int QUO_W         = NUM_DIV_CELLS;
  localparam int DVS_W         = BP_W + 1;           // 2*d
  localparam int REM_W         = DVS_W + QUO_W;      // holds up to 16*(2*d)
  localparam int MAG_W         = 7;
  localparam int OUT_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int PIPE_LATENCY  = 4 + NUM_DIV_CELLS;

  localparam logic [MAG_W-1:0] MAG_SAT = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_BP_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BP_MID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BP_TOP = 2'd2;

  localparam logic [CFG_DATA_W-1:0] BP_LOW_RST = 64'd231937176113184833;
  localparam logic [CFG_DATA_W-1:0] BP_MID_RST = 64'd1354470670535034171;
  localparam logic [BP_W-1:0]       BP_TOP_RST = 16'd8000;

  typedef logic [NUM_BP-1:0][BP_W-1:0] bp_arr_t;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'b00,  // below first breakpoint
    MODE_SAT  = 2'b01,  // at or above last breakpoint
    MODE_SEG  = 2'b10   // inside a segment, interpolate
  } mode_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    mode_t             mode;
    logic [SEG_W-1:0]  seg;
    logic [REM_W-1:0]  rem;
    logic [DVS_W-1:0]  dvs;
    logic [QUO_W-1:0]  quo;
  } div_cell_t;

endpackage

// ===== rtl/core/psl_front.sv =====
// ----------------------------------------------------------------------------
// Speed level mapper front end
// Magnitude and rounding, segment search, divider operand setup (3 stages).
// ----------------------------------------------------------------------------
`include "piecewise_speed_level_mapper_macros.svh"

module psl_front
  import psl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_take,
  input  logic signed [CMD_W-1:0] in_speed_command,
  input  bp_arr_t                 bp,
  output div_cell_t               cell_out
);

  typedef struct packed {
    logic              valid;
    logic              neg;
    mode_t             mode;
    logic [SEG_W-1:0]  seg;
    logic [BP_W-1:0]   n;
    logic [BP_W-1:0]   d;
  } seg_rec_t;

  // stage 1: sign, magnitude, round half up
  logic [CMD_W-1:0]   raw;
  logic [CMD_W-1:0]   mag;
  logic [CMD_W-1:0]   mag_rnd;
  logic               s1_valid_r;
  logic               s1_neg_r;
  logic [LEVEL_W-1:0] s1_level_r;

  assign raw     = in_speed_command;
  assign mag     = raw[CMD_W-1] ? (~raw + CMD_W'(1)) : raw;
  assign mag_rnd = mag + CMD_W'(8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
    s1_neg_r   <= raw[CMD_W-1];
    s1_level_r <= mag_rnd[CMD_W-1:4];
  end

  // stage 2: segment search and n, d
  logic [NUM_BP-1:0]   lt;
  logic                found;
  logic [SEG_W-1:0]    seg_sel;
  logic [BP_IDX_W-1:0] lo_idx;
  logic [BP_IDX_W-1:0] hi_idx;
  seg_rec_t            s2_nxt;
  seg_rec_t            s2_r;

  always_comb begin
    for (int k = 0; k < NUM_BP; k++) begin
      lt[k] = s1_level_r < {1'b0, bp[k]};
    end
    found   = 1'b0;
    seg_sel = '0;
    for (int k = 0; k < NUM_SEG; k++) begin
      if (!found && lt[k+1]) begin
        found   = 1'b1;
        seg_sel = SEG_W'(k);
      end
    end
    lo_idx = {1'b0, seg_sel};
    hi_idx = {1'b0, seg_sel} + BP_IDX_W'(1);

    s2_nxt.valid = s1_valid_r;
    s2_nxt.neg   = s1_neg_r;
    s2_nxt.seg   = seg_sel;
    if (lt[0]) begin
      s2_nxt.mode = MODE_ZERO;
    end else if (found) begin
      s2_nxt.mode = MODE_SEG;
    end else begin
      s2_nxt.mode = MODE_SAT;
    end
    // in a segment the level is below a 16-bit breakpoint
    s2_nxt.n = s1_level_r[BP_W-1:0] - bp[lo_idx];
    s2_nxt.d = bp[hi_idx] - bp[lo_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.neg  <= s2_nxt.neg;
    s2_r.mode <= s2_nxt.mode;
    s2_r.seg  <= s2_nxt.seg;
    s2_r.n    <= s2_nxt.n;
    s2_r.d    <= s2_nxt.d;
  end

  // stage 3: numerator 16n + d, divisor 2d
  div_cell_t s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r.valid <= s2_r.valid;
    end
    s3_r.neg  <= s2_r.neg;
    s3_r.mode <= s2_r.mode;
    s3_r.seg  <= s2_r.seg;
    s3_r.rem  <= {1'b0, s2_r.n, 4'b0000} + {{(REM_W-BP_W){1'b0}}, s2_r.d};
    s3_r.dvs  <= {s2_r.d, 1'b0};
    s3_r.quo  <= '0;
  end

  assign cell_out = s3_r;

  `PSL_ASSERT_IMP(a_seg_div_nonzero, clk, rst_n,
                  s2_r.valid && (s2_r.mode == MODE_SEG), s2_r.d != '0)
  `PSL_ASSERT_IMP(a_seg_n_below_d, clk, rst_n,
                  s2_r.valid && (s2_r.mode == MODE_SEG), s2_r.n < s2_r.d)

endmodule

// ===== rtl/core/psl_div_cell.sv =====
// ----------------------------------------------------------------------------
// Speed level mapper divider cell
// One restoring step: decides one quotient bit and passes the record on.
// ----------------------------------------------------------------------------
`include "piecewise_speed_level_mapper_macros.svh"

module psl_div_cell
  import psl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_cell_t cell_in,
  output div_cell_t cell_out
);

  logic [REM_W-1:0] dvs_top;
  logic [REM_W-1:0] diff;
  logic             ge;
  logic [REM_W-1:0] rem_keep;
  div_cell_t        cell_r;

  // compare against the divisor at the top quotient weight, then shift left
  assign dvs_top  = {1'b0, cell_in.dvs, {(QUO_W-1){1'b0}}};
  assign ge       = cell_in.rem >= dvs_top;
  assign diff     = cell_in.rem - dvs_top;
  assign rem_keep = ge ? diff : cell_in.rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_in.valid;
    end
    cell_r.neg  <= cell_in.neg;
    cell_r.mode <= cell_in.mode;
    cell_r.seg  <= cell_in.seg;
    cell_r.rem  <= {rem_keep[REM_W-2:0], 1'b0};
    cell_r.dvs  <= cell_in.dvs;
    cell_r.quo  <= {cell_in.quo[QUO_W-2:0], ge};
  end

  assign cell_out = cell_r;

  // partial remainder stays below 16 divisors, else a quotient bit is lost
  `PSL_ASSERT_IMP(a_rem_bound, clk, rst_n,
                  cell_in.valid && (cell_in.mode == MODE_SEG),
                  cell_in.rem < {cell_in.dvs, {QUO_W{1'b0}}})

endmodule

// ===== rtl/core/piecewise_speed_level_mapper.sv =====
// ----------------------------------------------------------------------------
// Piecewise speed level mapper
// Maps a signed Q16.4 speed command to a signed speed level of -64..64.
//
// Input: a command is taken at a rising edge with start high and busy low.
//   busy is high only during reset and the cycle after it; otherwise a new
//   command can be taken every cycle.
// Output: out_valid strobes for one cycle with out_speed_level; there is no
//   back-pressure, the receiver takes every result in that cycle.
// Pipeline: a command passes the front-end stages, the 4-cell divider
//   chain (one quotient bit per cell) and the output register. Throughput is
//   one command per cycle while busy is low.
// Config: cfg_index selects breakpoints_low (0), breakpoints_mid (1) or
//   breakpoint_top (2); other indexes are dropped. Write only when idle.
// Reset: synchronous active low; pipeline emptied and breakpoints set to
//   their default (pan) values.
// ----------------------------------------------------------------------------
`include "piecewise_speed_level_mapper_macros.svh"

module piecewise_speed_level_mapper
  import psl_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [CMD_W-1:0]      in_speed_command,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_speed_level,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  logic                  busy_r;
  logic                  in_take;
  logic [CFG_DATA_W-1:0] bp_low_r;
  logic [CFG_DATA_W-1:0] bp_mid_r;
  logic [BP_W-1:0]       bp_top_r;
  bp_arr_t               bp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign in_take   = start && !busy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_low_r <= BP_LOW_RST;
      bp_mid_r <= BP_MID_RST;
      bp_top_r <= BP_TOP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BP_LOW: bp_low_r <= cfg_data;
        REG_BP_MID: bp_mid_r <= cfg_data;
        REG_BP_TOP: bp_top_r <= cfg_data[BP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bp[k]   = bp_low_r[k*BP_W +: BP_W];
      bp[k+4] = bp_mid_r[k*BP_W +: BP_W];
    end
    bp[NUM_BP-1] = bp_top_r;
  end

  // front end and divider chain
  div_cell_t chain [NUM_DIV_CELLS+1];

  psl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_take          (in_take),
    .in_speed_command (in_speed_command),
    .bp               (bp),
    .cell_out         (chain[0])
  );

  for (genvar g = 0; g < NUM_DIV_CELLS; g++) begin : g_div
    psl_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  // output stage: 8*segment + quotient, then sign
  div_cell_t         tail;
  logic [MAG_W-1:0]  mag;
  logic [OUT_W-1:0]  mag_ext;
  logic [OUT_W-1:0]  level_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_level_r;

  assign tail = chain[NUM_DIV_CELLS];

  always_comb begin
    case (tail.mode)
      MODE_ZERO: mag = '0;
      MODE_SAT:  mag = MAG_SAT;
      MODE_SEG:  mag = {1'b0, tail.seg, 3'b000} + {{(MAG_W-QUO_W){1'b0}}, tail.quo};
      default:   mag = '0;
    endcase
    mag_ext   = {1'b0, mag};
    level_nxt = tail.neg ? (~mag_ext + OUT_W'(1)) : mag_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail.valid;
    end
    out_level_r <= level_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_speed_level = out_level_r;

  `PSL_ASSERT_DLY(a_latency, clk, rst_n, in_take, PIPE_LATENCY, out_valid)
  `PSL_ASSERT_IMP(a_level_range, clk, rst_n, out_valid,
                  (out_speed_level >= -8'sd64) && (out_speed_level <= 8'sd64))
  `PSL_ASSERT_IMP(a_seg_quo_range, clk, rst_n,
                  tail.valid && (tail.mode == MODE_SEG), tail.quo <= QUO_W'(8))

endmodule

// ===== dv/piecewise_speed_level_mapper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise speed level mapper testbench
// Drives speed commands through the start/busy port and predicts each level
// from a local copy of the breakpoint registers. Results are checked in order
// against the queue of predicted levels. Covers the reset table, monotonic,
// flat, degenerate and unordered breakpoint tables, and unmapped register
// writes.
// ----------------------------------------------------------------------------
module piecewise_speed_level_mapper_tb
  import psl_pkg::*;
();

  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_GAP        = 5;
  localparam int MAX_Q4         = 1048576;  // |most negative command|
  localparam int NUM_TABLES     = 10;
  localparam int TABLE_ITEMS    = 80;
  localparam int DEFAULT_ITEMS  = 150;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [CMD_W-1:0]  in_speed_command;
  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_speed_level;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  // local copy of the breakpoint registers
  logic [CFG_DATA_W-1:0] bp_low_q = BP_LOW_RST;
  logic [CFG_DATA_W-1:0] bp_mid_q = BP_MID_RST;
  logic [BP_W-1:0]       bp_top_q = BP_TOP_RST;

  logic signed [OUT_W-1:0] expected_levels [$];
  int  n_sent      = 0;
  int  n_done      = 0;
  int  errors      = 0;
  int  cycle_count = 0;
  bit  burst_mode  = 1'b0;

  piecewise_speed_level_mapper u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_speed_command (in_speed_command),
    .out_valid        (out_valid),
    .out_speed_level  (out_speed_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int breakpoint(input int k);
    if (k < 4) return int'(bp_low_q[16*k +: 16]);
    if (k < 8) return int'(bp_mid_q[16*(k-4) +: 16]);
    return int'(bp_top_q);
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_speed_level(
    input logic signed [CMD_W-1:0] cmd
  );
    int a, lvl, lo, hi, m;
    bit found;
    a     = (cmd < 0) ? -int'(cmd) : int'(cmd);
    lvl   = (a + 8) >> 4;
    m     = 64;
    found = 1'b0;
    if (lvl < breakpoint(0)) begin
      m = 0;
    end else begin
      // first segment whose upper breakpoint is above the level
      for (int k = 0; k < NUM_SEG; k++) begin
        if (!found && lvl < breakpoint(k + 1)) begin
          lo    = breakpoint(k);
          hi    = breakpoint(k + 1);
          m     = 8 * k + (16 * (lvl - lo) + (hi - lo)) / (2 * (hi - lo));
          found = 1'b1;
        end
      end
    end
    return (cmd < 0) ? OUT_W'(-m) : OUT_W'(m);
  endfunction

  // commands mostly near breakpoints and inside the table span
  function automatic logic signed [CMD_W-1:0] rand_speed();
    int lvl, a, sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return CMD_W'($urandom);
    if (sel == 2) return $urandom_range(0, 1) ? CMD_W'(MAX_Q4 - 1) : CMD_W'(-MAX_Q4);
    if (sel < 6) lvl = breakpoint($urandom_range(0, NUM_BP - 1)) + int'($urandom_range(0, 6)) - 3;
    else lvl = int'($urandom_range(0, breakpoint(NUM_BP - 1) + 20));
    a = lvl * 16 + int'($urandom_range(0, 15)) - 8;
    if (a < 0) a = 0;
    if (a > MAX_Q4) a = MAX_Q4;
    if ($urandom_range(0, 1)) return CMD_W'(-a);
    return CMD_W'((a >= MAX_Q4) ? MAX_Q4 - 1 : a);
  endfunction

  // predict on every command transfer, check every result, track config
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_levels.size() == 0) begin
          $error("speed_level: expected none, got %0d", out_speed_level);
          errors++;
        end else begin
          want = expected_levels.pop_front();
          if (out_speed_level !== want) begin
            $error("speed_level: expected %0d, got %0d", want, out_speed_level);
            errors++;
          end
          n_done++;
        end
      end
      if (start && !busy) expected_levels.push_back(predict_speed_level(in_speed_command));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BP_LOW: bp_low_q = cfg_data;
          REG_BP_MID: bp_mid_q = cfg_data;
          REG_BP_TOP: bp_top_q = cfg_data[BP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_command(input logic signed [CMD_W-1:0] cmd);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_speed_command <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (n_done < n_sent) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // writes all three registers plus an unmapped index that must be dropped
  task automatic load_table(input logic [CFG_DATA_W-1:0] low, mid, top_word);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_BP_LOW, REG_BP_MID, REG_BP_TOP, REG_UNMAPPED};
    val = '{low, mid, top_word, {$urandom, $urandom}};
    wait_for_drain();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_bp_list(input logic [BP_W-1:0] bp [NUM_BP]);
    load_table({bp[3], bp[2], bp[1], bp[0]}, {bp[7], bp[6], bp[5], bp[4]},
               {$urandom, 16'($urandom), bp[8]});
  endtask

  task automatic test_reset_table_directed();
    int pts [$];
    pts = '{0, 1, 7, 8, 24, -1, -8, 1031, 1032, 1040, -1040, 1775, 1776, 6000,
            30000, 127991, 127992, 128000, -128000, 1048575, -1048576, -1048575,
            500000, -77777};
    foreach (pts[k]) send_command(CMD_W'(pts[k]));
  endtask

  task automatic test_reset_table_random();
    for (int k = 0; k < DEFAULT_ITEMS; k++) begin
      burst_mode = (k >= 40 && k < 70);
      // hold off new commands until the pipeline is empty
      if (k == DEFAULT_ITEMS / 2) wait_for_drain();
      send_command(rand_speed());
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_breakpoint_tables();
    logic [BP_W-1:0] bp [NUM_BP];
    int step;
    for (int t = 0; t < NUM_TABLES; t++) begin
      case (t)
        0: bp = '{16'd40, 16'd90, 16'd300, 16'd700, 16'd1200, 16'd1900, 16'd2800,
                  16'd4300, 16'd7000};
        1: bp = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8};
        // repeated breakpoints give zero-width segments
        2: bp = '{16'd100, 16'd100, 16'd100, 16'd500, 16'd500, 16'd900, 16'd900,
                  16'd900, 16'd1600};
        3: bp = '{default: 16'd0};
        4: bp = '{default: 16'hFFFF};
        default: begin
          step  = (t == 7) ? 8000 : 200;
          bp[0] = BP_W'($urandom_range(0, 300));
          for (int k = 1; k < NUM_BP; k++) begin
            bp[k] = (int'(bp[k-1]) + step >= 65535) ? 16'hFFFF :
                    bp[k-1] + BP_W'($urandom_range(0, step));
          end
        end
      endcase
      if (t >= 8) load_table({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
      else load_bp_list(bp);
      burst_mode = (t % 3 == 0);
      repeat (TABLE_ITEMS) send_command(rand_speed());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_speed_command <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_table_directed();
    test_reset_table_random();
    test_breakpoint_tables();

    wait_for_drain();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (expected_levels.size() != 0) begin
      $error("speed_level: %0d expected results never arrived", expected_levels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/psl_pkg.sv
rtl/core/psl_front.sv
rtl/core/psl_div_cell.sv
rtl/core/piecewise_speed_level_mapper.sv
dv/piecewise_speed_level_mapper_tb.sv
